FILE: hdl/spu_adpcm_pkg.sv
// ----------------------------------------------------------------------------
// SPU ADPCM decoder package
// Payload types, block layout constants and the per-nibble decode function.
// ----------------------------------------------------------------------------
package spu_adpcm_pkg;

	localparam logic [3:0] POS_HEADER = 4'd0;
	localparam logic [3:0] POS_FLAGS  = 4'd1;
	localparam logic [3:0] POS_LAST   = 4'd15;
	localparam logic [3:0] SHIFT_MAX  = 4'd12;
	localparam logic [3:0] FILTER_MAX = 4'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       voice_start;
	} adpcm_in_t;

	typedef struct packed {
		logic signed [15:0] sample_first;
		logic signed [15:0] sample_second;
		logic               block_last;
		logic               voice_end;
	} adpcm_out_t;

	function automatic logic signed [7:0] tap_a(input logic [2:0] filt);
		logic signed [7:0] c;
		unique case (filt)
			3'd1:    c = 8'sd60;
			3'd2:    c = 8'sd115;
			3'd3:    c = 8'sd98;
			3'd4:    c = 8'sd122;
			default: c = 8'sd0;
		endcase
		return c;
	endfunction

	function automatic logic signed [7:0] tap_b(input logic [2:0] filt);
		logic signed [7:0] c;
		unique case (filt)
			3'd2:    c = -8'sd52;
			3'd3:    c = -8'sd55;
			3'd4:    c = -8'sd60;
			default: c = 8'sd0;
		endcase
		return c;
	endfunction

	// One sample: shifted nibble plus two-tap prediction / 64 (toward zero), clamped.
	function automatic logic signed [15:0] decode_sample(
		input logic [3:0]         nib,
		input logic [3:0]         shift,
		input logic [2:0]         filt,
		input logic signed [15:0] h1,
		input logic signed [15:0] h2
	);
		logic signed [15:0] base;
		logic signed [7:0]  ca;
		logic signed [7:0]  cb;
		logic signed [23:0] pa;
		logic signed [23:0] pb;
		logic signed [24:0] psum;
		logic signed [24:0] padj;
		logic signed [18:0] pred;
		logic signed [19:0] tot;
		logic signed [15:0] res;
		base = $signed({nib, 12'h000}) >>> shift;
		ca   = tap_a(filt);
		cb   = tap_b(filt);
		pa   = $signed({{16{ca[7]}}, ca}) * $signed({{8{h1[15]}}, h1});
		pb   = $signed({{16{cb[7]}}, cb}) * $signed({{8{h2[15]}}, h2});
		psum = $signed({pa[23], pa}) + $signed({pb[23], pb});
		// bias negatives so the shift truncates toward zero
		padj = psum[24] ? (psum + 25'sd63) : psum;
		pred = $signed(padj[24:6]);
		tot  = $signed({{4{base[15]}}, base}) + $signed({pred[18], pred});
		if (tot > 20'sd32767) begin
			res = 16'sh7FFF;
		end else if (tot < -20'sd32768) begin
			res = 16'sh8000;
		end else begin
			res = tot[15:0];
		end
		return res;
	endfunction

endpackage

FILE: hdl/spu_adpcm_decoder_unit.sv
// ----------------------------------------------------------------------------
// SPU ADPCM decoder unit
// Takes an ADPCM stream one byte per transfer and emits one sample pair for
// each data byte of a 16-byte block.
// ----------------------------------------------------------------------------
// Each input transfer passes an input register and then a result register.
// Throughput: one byte per cycle while the output is not stalled; the two-sample predictor chain is combinational.
// Header and flag bytes, and bytes after a finished voice, give no result.
// Reset clears history, block position, block settings and the done flag.
module spu_adpcm_decoder_unit
	import spu_adpcm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  adpcm_in_t  in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output adpcm_out_t out_data
);

	logic               valid_s1;
	adpcm_in_t          in_s1;
	logic               out_valid_q;
	adpcm_out_t         out_q;

	logic signed [15:0] h1_q, h2_q;
	logic [3:0]         pos_q;
	logic [3:0]         shift_q;
	logic [2:0]         filt_q;
	logic               endf_q;
	logic               done_q;

	logic signed [15:0] h1_e, h2_e;
	logic [3:0]         pos_e;
	logic               done_e;
	logic               produces;
	logic               advance;
	logic signed [15:0] s0, s1;
	logic               last;

	logic signed [15:0] h1_d, h2_d;
	logic [3:0]         pos_d;
	logic [3:0]         shift_d;
	logic [2:0]         filt_d;
	logic               endf_d;
	logic               done_d;

	// voice start clears history, position and done before the byte is used
	always_comb begin
		h1_e   = in_s1.voice_start ? 16'sd0 : h1_q;
		h2_e   = in_s1.voice_start ? 16'sd0 : h2_q;
		pos_e  = in_s1.voice_start ? POS_HEADER : pos_q;
		done_e = in_s1.voice_start ? 1'b0 : done_q;
	end

	assign produces = !done_e && (pos_e != POS_HEADER) && (pos_e != POS_FLAGS);
	assign advance  = valid_s1 && (!produces || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign s0   = decode_sample(in_s1.data_byte[3:0], shift_q, filt_q, h1_e, h2_e);
	assign s1   = decode_sample(in_s1.data_byte[7:4], shift_q, filt_q, s0, h1_e);
	assign last = (pos_e == POS_LAST);

	always_comb begin
		h1_d    = h1_e;
		h2_d    = h2_e;
		pos_d   = pos_e;
		shift_d = shift_q;
		filt_d  = filt_q;
		endf_d  = endf_q;
		done_d  = done_e;
		if (!done_e) begin
			priority if (pos_e == POS_HEADER) begin
				shift_d = (in_s1.data_byte[3:0] > SHIFT_MAX) ? SHIFT_MAX
					: in_s1.data_byte[3:0];
				filt_d  = (in_s1.data_byte[7:4] > FILTER_MAX) ? 3'd0
					: in_s1.data_byte[6:4];
				pos_d   = POS_FLAGS;
			end else if (pos_e == POS_FLAGS) begin
				endf_d = in_s1.data_byte[0];
				pos_d  = pos_e + 4'd1;
			end else begin
				h1_d   = s1;
				h2_d   = s0;
				pos_d  = last ? POS_HEADER : pos_e + 4'd1;
				done_d = last && endf_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h1_q    <= 16'sd0;
			h2_q    <= 16'sd0;
			pos_q   <= POS_HEADER;
			shift_q <= 4'd0;
			filt_q  <= 3'd0;
			endf_q  <= 1'b0;
			done_q  <= 1'b0;
		end else if (advance) begin
			h1_q    <= h1_d;
			h2_q    <= h2_d;
			pos_q   <= pos_d;
			shift_q <= shift_d;
			filt_q  <= filt_d;
			endf_q  <= endf_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && produces) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produces) begin
			out_q.sample_first  <= s0;
			out_q.sample_second <= s1;
			out_q.block_last    <= last;
			out_q.voice_end     <= last && endf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_q.voice_end || out_q.block_last))
		else $error("voice_end without block_last");

	a_result_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && produces) |-> (pos_e != POS_HEADER && pos_e != POS_FLAGS))
		else $error("result produced from header or flag byte");

	a_done_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && produces && last && endf_q) |=> done_q)
		else $error("voice not marked done after end block");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(in_s1)))
		else $error("stalled input stage changed");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(advance && produces))
		else $error("result register overwritten while held");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SPU ADPCM decoder unit testbench
// Feeds 16-byte ADPCM blocks through the valid/ready input, predicts each
// sample pair with a behavioral decoder and checks every output transfer in
// order. The sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module testbench
	import spu_adpcm_pkg::*;
();

	localparam int RANDOM_BYTES = 1450;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int TAP_ONE [5]  = '{0, 60, 115, 98, 122};
	localparam int TAP_TWO [5]  = '{0, 0, -52, -55, -60};

	typedef struct {
		adpcm_in_t  item;
		bit         typed;
		adpcm_out_t pair;
	} stim_row_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	adpcm_in_t  in_data   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	adpcm_out_t out_data;

	// decoder state as the predictor sees it
	int         hist_one;
	int         hist_two;
	logic [3:0] blk_pos;
	logic [3:0] blk_shift;
	logic [2:0] blk_filter;
	bit         blk_end;
	bit         voice_fin;

	adpcm_out_t pair_fifo [$];
	int         error_count = 0;
	int         cycle_count = 0;
	int         burst_left  = 0;
	int         bytes_taken = 0;
	int         stall_mode  = 0;
	int         stall_left  = 0;

	spu_adpcm_decoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #6 clk = ~clk;

	function automatic int decode_nib(input logic [3:0] nib);
		int smp;
		int pred;
		// nibble * 4096 is exact under shifts up to 12, so >>> gives the exact quotient
		smp  = ($signed(nib) * 4096) >>> blk_shift;
		pred = (TAP_ONE[blk_filter] * hist_one + TAP_TWO[blk_filter] * hist_two) / 64;
		smp  = smp + pred;
		if (smp > 32767) smp = 32767;
		if (smp < -32768) smp = -32768;
		hist_two = hist_one;
		hist_one = smp;
		return smp;
	endfunction

	function automatic bit predict_byte(input adpcm_in_t item, output adpcm_out_t pair);
		pair = '0;
		if (item.voice_start) begin
			hist_one  = 0;
			hist_two  = 0;
			blk_pos   = POS_HEADER;
			voice_fin = 1'b0;
		end
		if (voice_fin) return 1'b0;
		if (blk_pos == POS_HEADER) begin
			blk_shift  = (item.data_byte[3:0] > SHIFT_MAX) ? SHIFT_MAX : item.data_byte[3:0];
			blk_filter = (item.data_byte[7:4] > FILTER_MAX) ? 3'd0 : item.data_byte[6:4];
			blk_pos    = POS_FLAGS;
			return 1'b0;
		end
		if (blk_pos == POS_FLAGS) begin
			blk_end = item.data_byte[0];
			blk_pos = POS_FLAGS + 4'd1;
			return 1'b0;
		end
		pair.sample_first  = 16'(decode_nib(item.data_byte[3:0]));
		pair.sample_second = 16'(decode_nib(item.data_byte[7:4]));
		pair.block_last    = (blk_pos == POS_LAST);
		pair.voice_end     = pair.block_last && blk_end;
		if (pair.block_last) begin
			blk_pos   = POS_HEADER;
			voice_fin = blk_end;
		end else begin
			blk_pos = blk_pos + 4'd1;
		end
		return 1'b1;
	endfunction

	function automatic stim_row_t data_row(input logic [7:0] b, input bit start);
		stim_row_t r;
		r.item  = '{b, start};
		r.typed = 1'b0;
		r.pair  = '0;
		return r;
	endfunction

	function automatic stim_row_t known_row(input logic [7:0] b, input int lo, input int hi,
			input bit last, input bit vend);
		stim_row_t r;
		r.item  = '{b, 1'b0};
		r.typed = 1'b1;
		r.pair  = '{16'(lo), 16'(hi), last, vend};
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		error_count++;
	endtask

	task automatic send_byte(input adpcm_in_t item, input bit typed, input adpcm_out_t known);
		adpcm_out_t pair;
		bit         produced;
		bit         skipped;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		skipped  = voice_fin && !item.voice_start;
		produced = predict_byte(item, pair);
		if (typed) pair_fifo.push_back(known);
		else if (produced) pair_fifo.push_back(pair);
		if (!skipped) bytes_taken++;
	endtask

	// receiver: picks a new stall pattern whenever its current run ends
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 120);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= 1'($urandom_range(0, 1));
			2:       out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= (cycle_count % 5) != 0;
		endcase
	end

	always @(posedge clk) begin
		adpcm_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pair_fifo.size() == 0) begin
				report_mismatch("output transfer with no pair expected");
			end else begin
				want = pair_fifo.pop_front();
				if (out_data.sample_first !== want.sample_first)
					report_mismatch($sformatf("sample_first got %0d want %0d",
						out_data.sample_first, want.sample_first));
				if (out_data.sample_second !== want.sample_second)
					report_mismatch($sformatf("sample_second got %0d want %0d",
						out_data.sample_second, want.sample_second));
				if (out_data.block_last !== want.block_last)
					report_mismatch($sformatf("block_last got %b want %b",
						out_data.block_last, want.block_last));
				if (out_data.voice_end !== want.voice_end)
					report_mismatch($sformatf("voice_end got %b want %b",
						out_data.voice_end, want.voice_end));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		stim_row_t  stim_rows [$];
		adpcm_in_t  voice_bytes [$];
		int         nblk;
		int         ndata;
		bit         cut;
		bit         end_bit;
		logic [7:0] hdr;
		logic [7:0] dbyte;

		hist_one   = 0;
		hist_two   = 0;
		blk_pos    = POS_HEADER;
		blk_shift  = '0;
		blk_filter = '0;
		blk_end    = 1'b0;
		voice_fin  = 1'b0;

		// shift 13 clamps to 12, filter 5 falls back to 0, stray flag bits
		stim_rows.push_back(data_row(8'h5D, 1'b1));
		stim_rows.push_back(data_row(8'hFE, 1'b0));
		stim_rows.push_back(known_row(8'h7F, -1, 7, 1'b0, 1'b0));
		// restart mid-block; filter 15 falls back to 0, end flag set
		stim_rows.push_back(data_row(8'hF0, 1'b1));
		stim_rows.push_back(data_row(8'h01, 1'b0));
		stim_rows.push_back(known_row(8'h70, 0, 28672, 1'b0, 1'b0));
		stim_rows.push_back(known_row(8'h88, -32768, -32768, 1'b0, 1'b0));
		stim_rows.push_back(known_row(8'hFF, -4096, -4096, 1'b0, 1'b0));
		stim_rows.push_back(known_row(8'h00, 0, 0, 1'b0, 1'b0));
		stim_rows.push_back(known_row(8'h07, 28672, 0, 1'b0, 1'b0));
		stim_rows.push_back(known_row(8'h80, 0, -32768, 1'b0, 1'b0));
		stim_rows.push_back(known_row(8'h17, 28672, 4096, 1'b0, 1'b0));
		stim_rows.push_back(known_row(8'h71, 4096, 28672, 1'b0, 1'b0));
		stim_rows.push_back(known_row(8'h9F, -4096, -28672, 1'b0, 1'b0));
		stim_rows.push_back(known_row(8'hF9, -28672, -4096, 1'b0, 1'b0));
		stim_rows.push_back(known_row(8'h12, 8192, 4096, 1'b0, 1'b0));
		stim_rows.push_back(known_row(8'h34, 16384, 12288, 1'b0, 1'b0));
		stim_rows.push_back(known_row(8'h56, 24576, 20480, 1'b0, 1'b0));
		stim_rows.push_back(known_row(8'h78, -32768, 28672, 1'b1, 1'b1));
		// voice is done: dropped until the next start
		stim_rows.push_back(data_row(8'h44, 1'b0));
		stim_rows.push_back(data_row(8'hAB, 1'b0));
		// filter 4 with full-scale data drives the clamp
		stim_rows.push_back(data_row(8'h40, 1'b1));
		stim_rows.push_back(data_row(8'h00, 1'b0));
		stim_rows.push_back(data_row(8'h77, 1'b0));
		stim_rows.push_back(data_row(8'h88, 1'b0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i])
			send_byte(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].pair);

		bytes_taken = 0;
		while (bytes_taken < RANDOM_BYTES) begin
			voice_bytes.delete();
			nblk = $urandom_range(1, 5);
			cut  = 1'b0;
			for (int k = 0; k < nblk && !cut; k++) begin
				if ($urandom_range(0, 4) != 0)
					hdr = {4'($urandom_range(0, FILTER_MAX)), 4'($urandom_range(0, SHIFT_MAX))};
				else
					hdr = 8'($urandom);
				if (k == nblk - 1)
					end_bit = ($urandom_range(0, 2) != 0);
				else
					end_bit = ($urandom_range(0, 7) == 0);
				voice_bytes.push_back('{hdr, k == 0});
				voice_bytes.push_back('{{7'($urandom), end_bit}, 1'b0});
				ndata = 14;
				// occasionally abandon the block; the next voice restarts mid-block
				if ($urandom_range(0, 29) == 0) begin
					ndata = $urandom_range(0, 13);
					cut   = 1'b1;
				end
				for (int j = 0; j < ndata; j++) begin
					if ($urandom_range(0, 7) == 0) begin
						case ($urandom_range(0, 3))
							0:       dbyte = 8'h77;
							1:       dbyte = 8'h88;
							2:       dbyte = 8'h00;
							default: dbyte = 8'hFF;
						endcase
					end else begin
						dbyte = 8'($urandom);
					end
					voice_bytes.push_back('{dbyte, 1'b0});
				end
			end
			repeat ($urandom_range(0, 2)) voice_bytes.push_back('{8'($urandom), 1'b0});
			foreach (voice_bytes[i])
				send_byte(voice_bytes[i], 1'b0, '0);
		end

		in_valid <= 1'b0;
		while (pair_fifo.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
